// ===== sv/stvm_pkg.sv =====
package stvm_pkg;

    localparam int TABLE_LOG2  = 12;
    localparam int SLOT_COUNT  = 1 << TABLE_LOG2;
    localparam int FILL_LIMIT  = (SLOT_COUNT * 2) / 3;
    localparam int ADDR_W      = 64;
    localparam int HALF_W      = ADDR_W / 2;
    localparam int POS_W       = TABLE_LOG2;
    localparam int VAL_W       = TABLE_LOG2 + 1;
    localparam int GROUP_BITS  = 7;
    localparam int NB_MAX      = (VAL_W + GROUP_BITS - 1) / GROUP_BITS;
    localparam int PAD_W       = NB_MAX * GROUP_BITS;
    localparam int BYTE_IDX_W  = (NB_MAX > 1) ? $clog2(NB_MAX) : 1;
    localparam int ENTRY_W     = 1 + POS_W + ADDR_W;
    localparam logic [ADDR_W-1:0] FIB_FACTOR = 64'h9E37_79B9_7F4A_7C16;

    typedef enum logic [1:0] {
        STS_NEW     = 2'd0,
        STS_SEEN    = 2'd1,
        STS_FULL    = 2'd2,
        STS_CLEARED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MUL_LL = 2'd0,
        MUL_LH = 2'd1,
        MUL_HL = 2'd2
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_init;
        logic     acc_add;
        logic     slot_home;
        logic     slot_next;
        logic     ent_write;
        logic     clr_write;
        logic     cnt_clr;
        logic     res_set;
        t_status  res_status;
        logic     res_use_pos;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic present;
        logic match;
        logic full;
        logic probe_last;
        logic clr_last;
        logic out_free;
        logic byte_last;
    } t_dp_sts;

endpackage

// ===== sv/stvm_ram.sv =====
module stvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/stvm_dp.sv =====
module stvm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stvm_pkg::t_dp_cmd               i_cmd,
    output stvm_pkg::t_dp_sts               o_sts,
    input  logic [stvm_pkg::ADDR_W-1:0]     i_addr,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [7:0]                      o_m_tdata,
    output logic                            o_m_tlast,
    output logic [1:0]                      o_m_tuser
);

    logic [stvm_pkg::ADDR_W-1:0]     r_addr;
    logic [stvm_pkg::ADDR_W-1:0]     r_prod;
    logic [stvm_pkg::HALF_W-1:0]     r_acc_hi;
    logic [stvm_pkg::POS_W-1:0]      r_slot;
    logic [stvm_pkg::POS_W-1:0]      r_probe;
    logic [stvm_pkg::POS_W-1:0]      r_clr_idx;
    logic [stvm_pkg::POS_W-1:0]      r_count;
    logic [stvm_pkg::VAL_W-1:0]      r_val;
    logic [stvm_pkg::BYTE_IDX_W-1:0] r_left;
    stvm_pkg::t_status               r_status;
    logic                            r_ovalid;
    logic [7:0]                      r_odata;
    logic                            r_olast;
    stvm_pkg::t_status               r_ostatus;

    logic [stvm_pkg::HALF_W-1:0]     w_mul_a;
    logic [stvm_pkg::HALF_W-1:0]     w_mul_b;
    logic [stvm_pkg::HALF_W-1:0]     w_acc_sum;
    logic                            w_we;
    logic [stvm_pkg::POS_W-1:0]      w_waddr;
    logic [stvm_pkg::ENTRY_W-1:0]    w_wdata;
    logic [stvm_pkg::ENTRY_W-1:0]    w_rdata;
    logic                            w_rd_present;
    logic [stvm_pkg::POS_W-1:0]      w_rd_pos;
    logic [stvm_pkg::ADDR_W-1:0]     w_rd_addr;
    logic [stvm_pkg::VAL_W-1:0]      w_val_new;
    logic [stvm_pkg::PAD_W-1:0]      w_new_pad;
    logic [stvm_pkg::BYTE_IDX_W-1:0] w_left_new;
    logic [stvm_pkg::PAD_W-1:0]      w_cur_pad;
    logic [stvm_pkg::GROUP_BITS-1:0] w_grp;

    // low 64 bits of addr * factor: lo*lo + ((lo*hi + hi*lo) << 32)
    always_comb begin
        case (i_cmd.mul_sel)
            stvm_pkg::MUL_LL: begin
                w_mul_a = r_addr[stvm_pkg::HALF_W-1:0];
                w_mul_b = stvm_pkg::FIB_FACTOR[stvm_pkg::HALF_W-1:0];
            end
            stvm_pkg::MUL_LH: begin
                w_mul_a = r_addr[stvm_pkg::HALF_W-1:0];
                w_mul_b = stvm_pkg::FIB_FACTOR[stvm_pkg::ADDR_W-1:stvm_pkg::HALF_W];
            end
            stvm_pkg::MUL_HL: begin
                w_mul_a = r_addr[stvm_pkg::ADDR_W-1:stvm_pkg::HALF_W];
                w_mul_b = stvm_pkg::FIB_FACTOR[stvm_pkg::HALF_W-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_acc_sum = r_acc_hi + r_prod[stvm_pkg::HALF_W-1:0];

    // table entry: {present, position, address}
    assign w_we    = i_cmd.ent_write | i_cmd.clr_write;
    assign w_waddr = i_cmd.clr_write ? r_clr_idx : r_slot;
    assign w_wdata = i_cmd.clr_write ? '0 : {1'b1, r_count, r_addr};

    stvm_ram #(
        .WIDTH (stvm_pkg::ENTRY_W),
        .DEPTH (stvm_pkg::SLOT_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    assign w_rd_present = w_rdata[stvm_pkg::ENTRY_W-1];
    assign w_rd_pos     = w_rdata[stvm_pkg::ADDR_W +: stvm_pkg::POS_W];
    assign w_rd_addr    = w_rdata[stvm_pkg::ADDR_W-1:0];

    assign w_val_new = i_cmd.res_use_pos ?
                       ({1'b0, w_rd_pos} + stvm_pkg::VAL_W'(1)) : '0;
    assign w_new_pad = stvm_pkg::PAD_W'(w_val_new);

    // highest nonzero 7-bit group sets the byte count
    always_comb begin
        w_left_new = '0;
        for (int j = 1; j < stvm_pkg::NB_MAX; j++) begin
            if (|w_new_pad[j*stvm_pkg::GROUP_BITS +: stvm_pkg::GROUP_BITS]) begin
                w_left_new = stvm_pkg::BYTE_IDX_W'(j);
            end
        end
    end

    assign w_cur_pad = stvm_pkg::PAD_W'(r_val);
    assign w_grp     = w_cur_pad[r_left*stvm_pkg::GROUP_BITS +: stvm_pkg::GROUP_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.ent_write) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_addr;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.acc_init) begin
            r_acc_hi <= r_prod[stvm_pkg::ADDR_W-1:stvm_pkg::HALF_W];
        end else if (i_cmd.acc_add) begin
            r_acc_hi <= w_acc_sum;
        end
        if (i_cmd.slot_home) begin
            r_slot  <= w_acc_sum[stvm_pkg::HALF_W-1 -: stvm_pkg::POS_W];
            r_probe <= '0;
        end else if (i_cmd.slot_next) begin
            r_slot  <= r_slot + 1'b1;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.res_set) begin
            r_val    <= w_val_new;
            r_left   <= w_left_new;
            r_status <= i_cmd.res_status;
        end else if (i_cmd.out_load && (r_left != '0)) begin
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_odata   <= {(r_left != '0), w_grp};
            r_olast   <= (r_left == '0);
            r_ostatus <= r_status;
        end
    end

    assign o_sts.present    = w_rd_present;
    assign o_sts.match      = (w_rd_addr == r_addr);
    assign o_sts.full       = (r_count >= stvm_pkg::POS_W'(stvm_pkg::FILL_LIMIT));
    assign o_sts.probe_last = &r_probe;
    assign o_sts.clr_last   = &r_clr_idx;
    assign o_sts.out_free   = !r_ovalid || i_m_tready;
    assign o_sts.byte_last  = (r_left == '0);

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ostatus;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stvm_pkg::POS_W'(stvm_pkg::FILL_LIMIT))
        else $error("object count above fill limit");

    a_no_overwrite_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_m_tready))
        else $error("output beat overwritten before taken");

    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ent_write |-> (!w_rd_present && !o_sts.full))
        else $error("insert into occupied slot or full table");

endmodule

// ===== sv/stvm_ctrl.sv =====
module stvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_mode,
    output logic              o_s_tready,
    input  stvm_pkg::t_dp_sts i_sts,
    output stvm_pkg::t_dp_cmd o_cmd
);

    stvm_pkg::t_state r_state;
    stvm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stvm_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            stvm_pkg::ST_INIT: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = stvm_pkg::ST_IDLE;
                end
            end
            stvm_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_s_mode) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state = stvm_pkg::ST_CLEAR;
                    end else begin
                        n_state = stvm_pkg::ST_MUL0;
                    end
                end
            end
            stvm_pkg::ST_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = stvm_pkg::MUL_LL;
                n_state = stvm_pkg::ST_MUL1;
            end
            stvm_pkg::ST_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = stvm_pkg::MUL_LH;
                o_cmd.acc_init = 1'b1;
                n_state = stvm_pkg::ST_MUL2;
            end
            stvm_pkg::ST_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = stvm_pkg::MUL_HL;
                o_cmd.acc_add = 1'b1;
                n_state = stvm_pkg::ST_HASH;
            end
            stvm_pkg::ST_HASH: begin
                o_cmd.slot_home = 1'b1;
                n_state = stvm_pkg::ST_READ;
            end
            stvm_pkg::ST_READ: begin
                n_state = stvm_pkg::ST_CHECK;
            end
            stvm_pkg::ST_CHECK: begin
                if (!i_sts.present) begin
                    o_cmd.res_set = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.res_status = stvm_pkg::STS_FULL;
                    end else begin
                        o_cmd.ent_write  = 1'b1;
                        o_cmd.res_status = stvm_pkg::STS_NEW;
                    end
                    n_state = stvm_pkg::ST_EMIT;
                end else if (i_sts.match) begin
                    o_cmd.res_set     = 1'b1;
                    o_cmd.res_use_pos = 1'b1;
                    o_cmd.res_status  = stvm_pkg::STS_SEEN;
                    n_state = stvm_pkg::ST_EMIT;
                end else if (i_sts.probe_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = stvm_pkg::STS_FULL;
                    n_state = stvm_pkg::ST_EMIT;
                end else begin
                    o_cmd.slot_next = 1'b1;
                    n_state = stvm_pkg::ST_READ;
                end
            end
            stvm_pkg::ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = stvm_pkg::STS_CLEARED;
                    n_state = stvm_pkg::ST_EMIT;
                end
            end
            stvm_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.byte_last) begin
                        n_state = stvm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = stvm_pkg::ST_IDLE;
            end
        endcase
    end

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stvm_pkg::ST_CHECK) |-> ($past(r_state) == stvm_pkg::ST_READ))
        else $error("slot checked without a read");

endmodule

// ===== sv/sharing_table_varint_marker.sv =====
// channel | dir | tdata                   | tuser             | tlast
// s_*     | in  | [63:0] object_address   | [0] mode          | -
// m_*     | out | [7:0] out_byte          | [1:0] status      | last
//
// Lookup: after the accept beat the shared 32x32 multiplier makes three passes and
// HASH sets the home slot; each probe is a registered table read, then a check;
// result bytes then go one at a time into the output register as it frees.
// Clear: one write per slot, then one result beat.
// After reset the same clearing pass runs; s_tready stays low.
// Output register frees the input side: a new item is taken while the last
// beat waits on m_tready.
module sharing_table_varint_marker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] object_address
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] status
);

    stvm_pkg::t_dp_cmd w_cmd;
    stvm_pkg::t_dp_sts w_sts;

    stvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_mode   (s_tuser),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stvm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_addr     (s_tdata),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

endmodule

// ===== dv/sharing_table_varint_marker_test.sv =====
`timescale 1ns / 100ps

module sharing_table_varint_marker_test;

    localparam logic MODE_LOOKUP     = 1'b0;
    localparam logic MODE_CLEAR      = 1'b1;
    localparam int   RANDOM_ITEMS    = 180;
    localparam int   FILL_FRESH      = 160;
    localparam int   CALM_ITEMS      = 60;
    localparam int   TAIL_CYCLES     = 40;
    localparam int   WATCHDOG_LIMIT  = 40000;
    localparam int   MAX_PRINTS      = 40;
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        mode;
        logic [63:0] addr;
        logic        drain;
    } t_stim_item;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        stvm_pkg::t_status status;
    } t_marker_beat;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [63:0] object_address
    logic        s_tuser  = 1'b0;  // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;          // [1:0] status

    t_stim_item   pend_q[$];
    t_marker_beat marker_q[$];

    bit [stvm_pkg::SLOT_COUNT-1:0] table_present = '0;
    logic [63:0]                   table_addr[stvm_pkg::SLOT_COUNT];
    logic [stvm_pkg::POS_W-1:0]    table_pos[stvm_pkg::SLOT_COUNT];
    int                            table_count = 0;

    int   err_count   = 0;
    int   idle_cycles = 0;
    int   send_gap    = 0;
    int   rcv_gap     = 0;
    logic s_took      = 1'b0;

    sharing_table_varint_marker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [stvm_pkg::TABLE_LOG2-1:0] home_slot(input logic [63:0] a);
        logic [63:0] prod;
        prod = a * stvm_pkg::FIB_FACTOR;
        return prod[63 -: stvm_pkg::TABLE_LOG2];
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS)
            $display("%0t ns mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic add_item(input logic mode, input logic [63:0] addr, input logic drain);
        t_stim_item it;
        it.mode  = mode;
        it.addr  = addr;
        it.drain = drain;
        pend_q.push_back(it);
    endtask

    // Table lookup / insert, or clear; pushes the marker bytes this item produces.
    task automatic predict_marker(input logic mode, input logic [63:0] addr);
        logic [stvm_pkg::TABLE_LOG2-1:0] slot;
        logic [63:0]                     val;
        int                              nbytes;
        bit                              hit;
        bit                              free_found;
        t_marker_beat                    beat;
        beat.data = 8'h00;
        beat.last = 1'b1;
        if (mode == MODE_CLEAR) begin
            table_present = '0;
            table_count   = 0;
            beat.status   = stvm_pkg::STS_CLEARED;
            marker_q.push_back(beat);
            return;
        end
        slot       = home_slot(addr);
        hit        = 1'b0;
        free_found = 1'b0;
        for (int p = 0; p < stvm_pkg::SLOT_COUNT; p++) begin
            if (!table_present[slot]) begin
                free_found = 1'b1;
                break;
            end
            if (table_addr[slot] == addr) begin
                hit = 1'b1;
                break;
            end
            slot = slot + 1'b1;
        end
        if (hit) begin
            val    = 64'(table_pos[slot]) + 64'd1;
            nbytes = 1;
            while (nbytes < 3 && val >= (64'd1 << (7 * nbytes)))
                nbytes++;
            beat.status = stvm_pkg::STS_SEEN;
            for (int j = 0; j < nbytes; j++) begin
                beat.data = 8'((val >> (7 * (nbytes - 1 - j))) & 64'h7f);
                beat.last = (j == nbytes - 1);
                if (!beat.last)
                    beat.data[7] = 1'b1;
                marker_q.push_back(beat);
            end
        end else if (!free_found || table_count >= stvm_pkg::FILL_LIMIT) begin
            beat.status = stvm_pkg::STS_FULL;
            marker_q.push_back(beat);
        end else begin
            table_present[slot] = 1'b1;
            table_addr[slot]    = addr;
            table_pos[slot]     = stvm_pkg::POS_W'(table_count);
            table_count++;
            beat.status = stvm_pkg::STS_NEW;
            marker_q.push_back(beat);
        end
    endtask

    // sender
    always @(negedge i_clk) begin : drive_items
        logic        nv;
        logic        nu;
        logic [63:0] nd;
        t_stim_item  it;
        nv = s_tvalid;
        nu = s_tuser;
        nd = s_tdata;
        if (i_rst_n && (!s_tvalid || s_took)) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pend_q.size() > 0 && !(pend_q[0].drain && marker_q.size() > 0)) begin
                if (pend_q.size() > CALM_ITEMS && $urandom_range(7) == 0) begin
                    send_gap = $urandom_range(5);
                end else begin
                    it = pend_q.pop_front();
                    nv = 1'b1;
                    nu = it.mode;
                    nd = it.addr;
                end
            end
        end
        s_tvalid <= nv;
        s_tuser  <= nu;
        s_tdata  <= nd;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin : drive_ready
        logic nr;
        nr = 1'b1;
        if (rcv_gap > 0) begin
            nr = 1'b0;
            rcv_gap--;
        end else if (pend_q.size() > CALM_ITEMS && $urandom_range(7) == 0) begin
            nr = 1'b0;
            rcv_gap = $urandom_range(5);
        end
        m_tready <= nr;
    end

    always @(posedge i_clk) begin : check_results
        t_marker_beat want;
        s_took = 1'b0;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                s_took = 1'b1;
                predict_marker(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (marker_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat data %02h last %0b status %0d",
                                              m_tdata, m_tlast, m_tuser));
                end else begin
                    want = marker_q.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
                end
            end
            if (s_took || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** sharing_table_varint_marker: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] wrap_addr;
        logic [63:0] pool[$];
        logic [63:0] a;
        int          pick;
        int          fresh;

        // address whose home slot is the last one, so its twin wraps to slot 0
        wrap_addr = 64'd1;
        while (home_slot(wrap_addr) !=
               stvm_pkg::TABLE_LOG2'(stvm_pkg::SLOT_COUNT - 1))
            wrap_addr++;

        // directed: extremes, top-bit twins share a home slot, wrap, clear
        add_item(MODE_LOOKUP, 64'd0, 1'b0);
        add_item(MODE_LOOKUP, 64'd0, 1'b0);
        add_item(MODE_LOOKUP, '1, 1'b0);
        add_item(MODE_LOOKUP, TOP_BIT, 1'b0);
        add_item(MODE_LOOKUP, TOP_BIT, 1'b0);
        add_item(MODE_LOOKUP, wrap_addr, 1'b0);
        add_item(MODE_LOOKUP, wrap_addr ^ TOP_BIT, 1'b0);
        add_item(MODE_LOOKUP, wrap_addr ^ TOP_BIT, 1'b0);
        add_item(MODE_LOOKUP, wrap_addr, 1'b0);
        add_item(MODE_LOOKUP, '1, 1'b0);
        add_item(MODE_LOOKUP, ~TOP_BIT, 1'b0);
        add_item(MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_item(MODE_LOOKUP, 64'h5555_5555_5555_5555, 1'b0);
        add_item(MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_item(MODE_LOOKUP, 64'd1, 1'b0);
        add_item(MODE_CLEAR, '1, 1'b0);
        add_item(MODE_LOOKUP, TOP_BIT, 1'b0);
        add_item(MODE_LOOKUP, 64'd0, 1'b0);
        add_item(MODE_LOOKUP, 64'd0, 1'b0);
        add_item(MODE_LOOKUP, 64'h5555_5555_5555_5555, 1'b0);
        add_item(MODE_CLEAR, 64'd0, 1'b0);
        add_item(MODE_LOOKUP, '1, 1'b0);

        // random mix of repeats, fresh addresses, twins and rare clears
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                add_item(MODE_CLEAR, {$urandom, $urandom}, i == RANDOM_ITEMS / 2);
            end else if (pick < 45 && pool.size() > 0) begin
                add_item(MODE_LOOKUP, pool[$urandom_range(pool.size() - 1)],
                         i == RANDOM_ITEMS / 2);
            end else begin
                if (pick < 55 && pool.size() > 0)
                    a = pool[$urandom_range(pool.size() - 1)] ^ TOP_BIT;
                else if (pick < 60)
                    a = 64'($urandom_range(31));
                else
                    a = {$urandom, $urandom};
                pool.push_back(a);
                add_item(MODE_LOOKUP, a, i == RANDOM_ITEMS / 2);
            end
        end

        // run the count past 127 so repeats take two marker bytes
        pool.delete();
        add_item(MODE_CLEAR, {$urandom, $urandom}, 1'b1);
        fresh = 0;
        while (fresh < FILL_FRESH) begin
            if (pool.size() > 0 && $urandom_range(7) == 0) begin
                add_item(MODE_LOOKUP, pool[$urandom_range(pool.size() - 1)], 1'b0);
            end else begin
                a = {$urandom, $urandom};
                pool.push_back(a);
                add_item(MODE_LOOKUP, a, 1'b0);
                fresh++;
            end
        end
        for (int i = 0; i < 40; i++)
            add_item(MODE_LOOKUP, pool[$urandom_range(pool.size() - 1)], 1'b0);
        add_item(MODE_CLEAR, 64'd0, 1'b0);
        add_item(MODE_LOOKUP, pool[0], 1'b0);
        add_item(MODE_LOOKUP, pool[0], 1'b0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() > 0 || s_tvalid)
            @(posedge i_clk);
        while (marker_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && marker_q.size() == 0) begin
            $display("** sharing_table_varint_marker: PASSED **");
        end else begin
            $display("** sharing_table_varint_marker: FAILED **");
        end
        $finish;
    end

endmodule
